>>> rtl/clt_pkg.sv
package clt_pkg;

    // address limits
    localparam int LBA_BITS = 48;
    localparam int LBA_W    = 48;
    localparam int CYL_W    = 32;
    localparam int FWD_W    = LBA_W + 1;
    localparam logic [LBA_W-1:0] LBA_LIMIT =
        (LBA_BITS >= LBA_W) ? {LBA_W{1'b1}} : LBA_W'((64'd1 << LBA_BITS) - 64'd1);

    // quotient bits resolved per divider stage
    localparam int DIV_STEP = 4;
    localparam int CYL_STAGES = LBA_W / DIV_STEP;
    localparam int TRK_STAGES = 16 / DIV_STEP;

    // geometry reset values
    localparam logic [7:0] HPC_RESET = 8'd16;
    localparam logic [7:0] SPT_RESET = 8'd63;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_GEOMETRY = 2'd1,
        ST_SECTOR   = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        CFG_HPC = 1'b0,
        CFG_SPT = 1'b1
    } cfg_idx_t;

    // request context carried down the pipeline
    typedef struct packed {
        logic             op;
        logic             geom_bad;
        logic             sec_bad;
        logic [7:0]       hpc;
        logic [7:0]       spt;
        logic [CYL_W-1:0] cyl;
        logic [7:0]       head;
        logic [7:0]       sec;
        logic [LBA_W-1:0] lba;
        logic [15:0]      per_cyl;
        logic [FWD_W-1:0] fwd;
        logic [LBA_W-1:0] quo;
        logic [15:0]      rem;
        logic [15:0]      d2;
        logic [7:0]       r2;
    } pipe_t;

endpackage

>>> rtl/clt_front.sv
module clt_front
    import clt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_op,
    input  logic [CYL_W-1:0] in_cyl,
    input  logic [7:0]       in_head,
    input  logic [7:0]       in_sec,
    input  logic [LBA_W-1:0] in_lba,
    input  logic [7:0]       hpc,
    input  logic [7:0]       spt,
    output logic             out_valid,
    input  logic             out_ready,
    output pipe_t            out_data
);

    logic [2:0] valid_reg;
    pipe_t      data_reg [3];
    pipe_t      data_next [3];
    logic [3:0] rdy;

    // per-stage ready chain
    always_comb
    begin
        rdy[3] = out_ready;
        for (int i = 2; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    // stage 0: capture request and geometry, stage 1: c*hpc, stage 2: full lba
    always_comb
    begin
        logic [FWD_W-1:0] t;
        data_next[0]          = '0;
        data_next[0].op       = in_op;
        data_next[0].hpc      = hpc;
        data_next[0].spt      = spt;
        data_next[0].geom_bad = (hpc == 8'd0) || (spt == 8'd0);
        data_next[0].sec_bad  = (in_sec == 8'd0);
        data_next[0].cyl      = in_cyl;
        data_next[0].head     = in_head;
        data_next[0].sec      = in_sec;
        data_next[0].lba      = in_lba;

        data_next[1]         = data_reg[0];
        data_next[1].fwd     = {17'd0, data_reg[0].cyl} * {41'd0, data_reg[0].hpc};
        data_next[1].per_cyl = {8'd0, data_reg[0].hpc} * {8'd0, data_reg[0].spt};

        data_next[2]     = data_reg[1];
        t                = data_reg[1].fwd + {41'd0, data_reg[1].head};
        data_next[2].fwd = t * {41'd0, data_reg[1].spt}
                         + {41'd0, data_reg[1].sec - 8'd1};
        data_next[2].quo = data_reg[1].lba;
        data_next[2].rem = 16'd0;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0]) valid_reg[0] <= in_valid;
            if (rdy[1]) valid_reg[1] <= valid_reg[0];
            if (rdy[2]) valid_reg[2] <= valid_reg[1];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (rdy[i]) data_reg[i] <= data_next[i];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[2];
    assign out_data  = data_reg[2];

endmodule

>>> rtl/clt_cyl_div.sv
module clt_cyl_div
    import clt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  pipe_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output pipe_t out_data
);

    logic [CYL_STAGES-1:0] valid_reg;
    pipe_t                 data_reg  [CYL_STAGES];
    pipe_t                 data_next [CYL_STAGES];
    logic [CYL_STAGES:0]   rdy;

    // restoring division of lba by hpc*spt, four quotient bits per stage
    function automatic pipe_t div_step(input pipe_t p);
        pipe_t       r;
        logic [16:0] x;
        r = p;
        for (int k = 0; k < DIV_STEP; k++)
        begin
            x     = {r.rem, r.quo[LBA_W-1]};
            r.quo = {r.quo[LBA_W-2:0], 1'b0};
            if (x >= {1'b0, r.per_cyl})
            begin
                x        = x - {1'b0, r.per_cyl};
                r.quo[0] = 1'b1;
            end
            r.rem = x[15:0];
        end
        return r;
    endfunction

    always_comb
    begin
        rdy[CYL_STAGES] = out_ready;
        for (int i = CYL_STAGES - 1; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    always_comb
    begin
        data_next[0] = div_step(in_data);
        for (int i = 1; i < CYL_STAGES; i++)
        begin
            data_next[i] = div_step(data_reg[i-1]);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0]) valid_reg[0] <= in_valid;
            for (int i = 1; i < CYL_STAGES; i++)
            begin
                if (rdy[i]) valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CYL_STAGES; i++)
        begin
            if (rdy[i]) data_reg[i] <= data_next[i];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[CYL_STAGES-1];
    assign out_data  = data_reg[CYL_STAGES-1];

endmodule

>>> rtl/clt_trk_div.sv
module clt_trk_div
    import clt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  pipe_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output pipe_t out_data
);

    logic [TRK_STAGES-1:0] valid_reg;
    pipe_t                 data_reg  [TRK_STAGES];
    pipe_t                 data_next [TRK_STAGES];
    logic [TRK_STAGES:0]   rdy;

    // restoring division of the cylinder remainder by spt
    function automatic pipe_t div_step(input pipe_t p);
        pipe_t      r;
        logic [8:0] x;
        r = p;
        for (int k = 0; k < DIV_STEP; k++)
        begin
            x    = {r.r2, r.d2[15]};
            r.d2 = {r.d2[14:0], 1'b0};
            if (x >= {1'b0, r.spt})
            begin
                x       = x - {1'b0, r.spt};
                r.d2[0] = 1'b1;
            end
            r.r2 = x[7:0];
        end
        return r;
    endfunction

    always_comb
    begin
        rdy[TRK_STAGES] = out_ready;
        for (int i = TRK_STAGES - 1; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    always_comb
    begin
        pipe_t s;
        s    = in_data;
        s.d2 = in_data.rem;
        s.r2 = 8'd0;
        data_next[0] = div_step(s);
        for (int i = 1; i < TRK_STAGES; i++)
        begin
            data_next[i] = div_step(data_reg[i-1]);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0]) valid_reg[0] <= in_valid;
            for (int i = 1; i < TRK_STAGES; i++)
            begin
                if (rdy[i]) valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TRK_STAGES; i++)
        begin
            if (rdy[i]) data_reg[i] <= data_next[i];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[TRK_STAGES-1];
    assign out_data  = data_reg[TRK_STAGES-1];

endmodule

>>> rtl/chs_lba_translator_core.sv
// chs/lba address translator
// input stream: s_axis_tuser selects the direction (0 chs to lba, 1 lba to chs),
// s_axis_tdata carries cylinder, head, one-based sector and lba.
// output stream: m_axis_tdata carries status, lba, cylinder, head and sector;
// fields not produced by the request, and all result fields on an error, are zero.
// geometry (heads per cylinder, sectors per track) is written through cfg_we/cfg_addr/
// cfg_wdata; the user writes it only while no request is in flight (not enforced by the block).
// a request passes from input to output valid through 3 front stages
// (capture, c*hpc, full lba), 12 stages of the lba / (hpc*spt) divider at
// 4 quotient bits each, 4 stages of the remainder / spt divider and the
// output register.
// throughput is one request per cycle while the receiver is ready; every stage has its own valid bit,
// so a stalled receiver only holds the stages that are full and the
// input keeps taking requests until the pipeline is full.
// reset clears all valid bits and restores geometry to 16 heads, 63 sectors.
module chs_lba_translator_core
    import clt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // cylinder_in, head_in, sector_in, lba_in
    input  logic         s_axis_tuser,  // operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,  // status, lba_out, cylinder_out, head_out, sector_out
    input  logic         cfg_we,
    input  logic [0:0]   cfg_addr,
    input  logic [7:0]   cfg_wdata
);

    logic [7:0] hpc_reg;
    logic [7:0] spt_reg;

    logic  f_valid, f_ready, c_valid, c_ready, t_valid, t_ready;
    pipe_t f_data, c_data, t_data;

    logic         out_valid_reg;
    logic [103:0] out_data_reg;
    logic [103:0] out_data_next;

    // geometry registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hpc_reg <= HPC_RESET;
            spt_reg <= SPT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_HPC: hpc_reg <= cfg_wdata;
                CFG_SPT: spt_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    clt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser),
        .in_cyl    (s_axis_tdata[31:0]),
        .in_head   (s_axis_tdata[39:32]),
        .in_sec    (s_axis_tdata[47:40]),
        .in_lba    (s_axis_tdata[95:48]),
        .hpc       (hpc_reg),
        .spt       (spt_reg),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    clt_cyl_div u_cyl_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_data  (c_data)
    );

    clt_trk_div u_trk_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_data   (c_data),
        .out_valid (t_valid),
        .out_ready (t_ready),
        .out_data  (t_data)
    );

    // status priority and result selection
    always_comb
    begin
        status_t          st;
        logic [LBA_W-1:0] lba_o;
        logic [CYL_W-1:0] cyl_o;
        logic [7:0]       head_o;
        logic [7:0]       sec_o;
        st     = ST_OK;
        lba_o  = '0;
        cyl_o  = '0;
        head_o = '0;
        sec_o  = '0;
        if (t_data.geom_bad)
        begin
            st = ST_GEOMETRY;
        end
        else if (!t_data.op)
        begin
            if (t_data.sec_bad)
                st = ST_SECTOR;
            else if (t_data.fwd > {1'b0, LBA_LIMIT})
                st = ST_OVERFLOW;
            else
                lba_o = t_data.fwd[LBA_W-1:0];
        end
        else
        begin
            if (t_data.lba > LBA_LIMIT)
                st = ST_OVERFLOW;
            else if (t_data.quo[LBA_W-1:CYL_W] != '0)
                st = ST_OVERFLOW;
            else
            begin
                cyl_o  = t_data.quo[CYL_W-1:0];
                head_o = t_data.d2[7:0];
                sec_o  = t_data.r2 + 8'd1;
            end
        end
        out_data_next = {6'd0, sec_o, head_o, cyl_o, lba_o, st};
    end

    assign t_ready = !out_valid_reg || m_axis_tready;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (t_ready)
            out_valid_reg <= t_valid;
    end

    always_ff @(posedge clk)
    begin
        if (t_ready)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
